### rtl/scd_pkg.sv
// scan code key decoder: shared types and constants
// used by the core, the table ram users and the port checker
`default_nettype none

package scd_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_kind;

    // item kinds
    localparam t_kind KIND_SCAN     = 2'd0;
    localparam t_kind KIND_KEY_WR   = 2'd1;
    localparam t_kind KIND_SHIFT_WR = 2'd2;

    // translated code meanings
    localparam t_byte RELEASE_MARK = 8'hF0;
    localparam t_byte SHIFT_CODE   = 8'd16;
    localparam t_byte CTRL_CODE    = 8'd17;
    localparam t_byte ASCII_A      = 8'd65;
    localparam t_byte ASCII_Z      = 8'd90;
    localparam t_byte CASE_OFFSET  = 8'd32;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        t_byte code;
        logic  released;
        logic  shift_down;
        logic  ctrl_down;
    } t_result;

endpackage

`default_nettype wire

### rtl/scan_code_key_decoder_core.sv
// scan code key decoder top level: key and shift tables in ram, modifier flags,
// result queue; depends on scd_pkg and scd_ram
//
// Takes one beat per cycle once ready. A scan byte's result passes the key table
// read, then the shift table read addressed by the translated code, before it
// enters the result queue. It shows on the outputs from the cycle after that.
// Table writes and ignored bytes give no result. After reset the block clears
// both tables in a pass over every address and holds o_ready low during it.
// A four-entry result queue lets input beats flow while results wait, until full.
`default_nettype none

module scan_code_key_decoder_core #(
    parameter int CODE_COUNT = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire scd_pkg::t_kind i_kind,
    input  wire scd_pkg::t_byte i_code_byte,
    input  wire scd_pkg::t_byte i_table_value,
    output logic               o_valid,
    input  wire logic          i_ready,
    output scd_pkg::t_byte     o_key_code,
    output logic               o_released,
    output logic               o_shift_down,
    output logic               o_ctrl_down
);

    import scd_pkg::*;

    localparam int              AW         = $clog2(CODE_COUNT);
    localparam logic [AW-1:0]   LAST_ADDR  = AW'(CODE_COUNT - 1);
    localparam logic [8:0]      CODE_LIMIT = 9'(CODE_COUNT);

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // flags
    logic r_rel_armed, r_shift_held, r_ctrl_held;
    logic n_rel_armed, n_shift_held, n_ctrl_held;

    // stage 1: key table data arrives
    logic r_s1_vld, r_s1_in_range;
    // stage 2: shift table data arrives
    logic    r_s2_vld, r_s2_sub;
    t_result r_s2_res;

    // result queue
    t_result            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   fill;

    logic    accept, in_range, push, pop;
    logic    key_we, shift_we;
    t_byte   key_rdata, shift_rdata;
    t_byte   t_code, lower;
    logic    is_key, lower_in_range;
    t_result s2_out;

    assign accept   = i_valid && o_ready;
    assign in_range = {1'b0, i_code_byte} < CODE_LIMIT;

    // every item in flight may still claim one queue slot
    assign fill    = r_cnt + CNT_W'(r_s1_vld) + CNT_W'(r_s2_vld);
    assign o_ready = !r_clr_busy && (fill < CNT_W'(FIFO_DEPTH));

    assign key_we   = r_clr_busy || (accept && i_kind == KIND_KEY_WR && in_range);
    assign shift_we = r_clr_busy || (accept && i_kind == KIND_SHIFT_WR && in_range);

    scd_ram #(
        .WIDTH (8),
        .DEPTH (CODE_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_clr_busy ? r_clr_addr : i_code_byte[AW-1:0]),
        .i_wdata (r_clr_busy ? 8'h00 : i_table_value),
        .i_raddr (i_code_byte[AW-1:0]),
        .o_rdata (key_rdata)
    );

    // the shift read is for an older beat than a write in the same cycle,
    // so the old-data read order is the right one
    scd_ram #(
        .WIDTH (8),
        .DEPTH (CODE_COUNT)
    ) u_shift_ram (
        .i_clk   (i_clk),
        .i_we    (shift_we),
        .i_waddr (r_clr_busy ? r_clr_addr : i_code_byte[AW-1:0]),
        .i_wdata (r_clr_busy ? 8'h00 : i_table_value),
        .i_raddr (lower[AW-1:0]),
        .o_rdata (shift_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage 1 decode
    always_comb begin
        t_code       = r_s1_in_range ? key_rdata : 8'h00;
        n_rel_armed  = r_rel_armed;
        n_shift_held = r_shift_held;
        n_ctrl_held  = r_ctrl_held;
        is_key       = 1'b0;
        lower        = (t_code inside {[ASCII_A:ASCII_Z]}) ? t_code + CASE_OFFSET : t_code;
        if (r_s1_vld) begin
            n_rel_armed = 1'b0;
            if (t_code == 8'h00) begin
                n_rel_armed = 1'b0;
            end else if (!r_rel_armed && t_code == RELEASE_MARK) begin
                n_rel_armed = 1'b1;
            end else if (t_code == SHIFT_CODE) begin
                n_shift_held = !r_rel_armed;
            end else if (t_code == CTRL_CODE) begin
                n_ctrl_held = !r_rel_armed;
            end else begin
                is_key = 1'b1;
            end
        end
    end

    assign lower_in_range = {1'b0, lower} < CODE_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_rel_armed  <= 1'b0;
            r_shift_held <= 1'b0;
            r_ctrl_held  <= 1'b0;
        end else begin
            r_s1_vld     <= accept && i_kind == KIND_SCAN;
            r_s2_vld     <= r_s1_vld && is_key;
            r_rel_armed  <= n_rel_armed;
            r_shift_held <= n_shift_held;
            r_ctrl_held  <= n_ctrl_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_in_range       <= in_range;
        r_s2_sub            <= r_shift_held && lower_in_range;
        r_s2_res.code       <= lower;
        r_s2_res.released   <= r_rel_armed;
        r_s2_res.shift_down <= r_shift_held;
        r_s2_res.ctrl_down  <= r_ctrl_held;
    end

    // stage 2 shift substitution
    always_comb begin
        s2_out = r_s2_res;
        if (r_s2_sub && shift_rdata != 8'h00) begin
            s2_out.code = shift_rdata;
        end
    end

    assign push = r_s2_vld;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s2_out;
        end
    end

    assign o_valid      = r_cnt != '0;
    assign o_key_code   = r_fifo[r_rd_ptr].code;
    assign o_released   = r_fifo[r_rd_ptr].released;
    assign o_shift_down = r_fifo[r_rd_ptr].shift_down;
    assign o_ctrl_down  = r_fifo[r_rd_ptr].ctrl_down;

endmodule

`default_nettype wire

### rtl/scd_ram.sv
// scan code key decoder: generic single write, single read ram
// registered read returns the old word on a same-address write; no dependencies
`default_nettype none

module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/scd_checker.sv
// scan code key decoder: port-level checker and its bind to the top level
// depends on scd_pkg
`default_nettype none

module scd_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire logic          o_ready,
    input wire scd_pkg::t_kind i_kind,
    input wire scd_pkg::t_byte i_code_byte,
    input wire scd_pkg::t_byte i_table_value,
    input wire logic          o_valid,
    input wire logic          i_ready,
    input wire scd_pkg::t_byte o_key_code,
    input wire logic          o_released,
    input wire logic          o_shift_down,
    input wire logic          o_ctrl_down
);

    import scd_pkg::*;

    // reset empties the queue and starts the table clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("outputs active right after reset");

    // an empty queue only fills from a scan beat taken earlier
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_kind == KIND_SCAN, 3))
        else $error("result without a scan beat three cycles before");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_key_code) && $stable(o_released)
            && $stable(o_shift_down) && $stable(o_ctrl_down))
        else $error("stalled result changed");

endmodule

bind scan_code_key_decoder_core scd_checker u_scd_checker (.*);

`default_nettype wire
